// ----- hw/rtl/dtdz_pkg.sv -----
package dtdz_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int ACC_FRAC = 16;
    localparam int SQRT_STEPS = 24;

    localparam int IN_W = 16;
    localparam int SQ_W = 32;
    localparam int REM_W = 48;
    localparam int ROOT_W = 24;
    localparam int VEC_W = 28;
    localparam int ACC_W = 25;
    localparam int PITCH_W = 14;
    localparam int DELTA_W = 15;
    localparam int ZONE_W = 2;
    localparam int GREEN_W = 13;
    localparam int YELLOW_W = 14;
    localparam int STEP_W = 5;

    localparam logic [ZONE_W-1:0] ZONE_STOP   = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_GREEN  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_YELLOW = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_RED    = 2'd3;

    localparam logic [GREEN_W-1:0]  GREEN_RESET  = 13'd960;
    localparam logic [YELLOW_W-1:0] YELLOW_RESET = 14'd2560;

    localparam logic REG_GREEN  = 1'b0;
    localparam logic REG_YELLOW = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQ_SUM,
        OP_SQRT,
        OP_CINIT,
        OP_CITER,
        OP_CFIN,
        OP_DIFF
    } op_t;

    typedef struct packed {
        logic              capture;
        logic              load_out;
        logic              run;
        logic              sel_b;
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic [22:0] atan_lookup(input logic [STEP_W-1:0] idx);
        logic [22:0] v;
        unique case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/dtdz_ctrl.sv -----
module dtdz_ctrl
    import dtdz_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic button_level,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    localparam int N_ITER = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ?
                            ATAN_TABLE_LEN : CORDIC_ITERATIONS;
    localparam logic [STEP_W-1:0] ITER_LAST = STEP_W'(N_ITER - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_SQRT,
        ST_CINIT,
        ST_CITER,
        ST_CFIN,
        ST_DIFF,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic              run_reg;
    logic              prev_button_reg;
    logic              sel_b_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_tvalid_reg;
    logic              run_next;
    logic              out_free;

    assign run_next = run_reg ^ (~button_level & prev_button_reg);
    assign out_free = ~m_tvalid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.capture  = (state_reg == ST_IDLE) & s_tvalid;
        cmd.load_out = (state_reg == ST_EMIT) & out_free;
        cmd.run      = run_reg;
        cmd.sel_b    = sel_b_reg;
        cmd.step     = step_reg;
        unique case (state_reg)
            ST_SQ_Y:   cmd.op = OP_SQ_Y;
            ST_SQ_Z:   cmd.op = OP_SQ_Z;
            ST_SQ_SUM: cmd.op = OP_SQ_SUM;
            ST_SQRT:   cmd.op = OP_SQRT;
            ST_CINIT:  cmd.op = OP_CINIT;
            ST_CITER:  cmd.op = OP_CITER;
            ST_CFIN:   cmd.op = OP_CFIN;
            ST_DIFF:   cmd.op = OP_DIFF;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            run_reg         <= 1'b0;
            prev_button_reg <= 1'b1;
            sel_b_reg       <= 1'b0;
            step_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= ((state_reg == ST_EMIT) & out_free) | (m_tvalid_reg & ~m_tready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        prev_button_reg <= button_level;
                        run_reg         <= run_next;
                        sel_b_reg       <= 1'b0;
                        step_reg        <= '0;
                        state_reg       <= run_next ? ST_SQ_Y : ST_EMIT;
                    end
                end
                ST_SQ_Y:   state_reg <= ST_SQ_Z;
                ST_SQ_Z:   state_reg <= ST_SQ_SUM;
                ST_SQ_SUM:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (step_reg == SQRT_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_CINIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_CINIT:  state_reg <= ST_CITER;
                ST_CITER:
                begin
                    if (step_reg == ITER_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_CFIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_CFIN:
                begin
                    if (!sel_b_reg)
                    begin
                        sel_b_reg <= 1'b1;
                        state_reg <= ST_SQ_Y;
                    end
                    else
                    begin
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:   state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/dtdz_datapath.sv -----
module dtdz_datapath
    import dtdz_pkg::*;
(
    input  logic                       clk,
    input  cmd_t                       cmd,
    input  logic signed [IN_W-1:0]     accel_a_x,
    input  logic signed [IN_W-1:0]     accel_a_y,
    input  logic signed [IN_W-1:0]     accel_a_z,
    input  logic signed [IN_W-1:0]     accel_b_x,
    input  logic signed [IN_W-1:0]     accel_b_y,
    input  logic signed [IN_W-1:0]     accel_b_z,
    input  logic [GREEN_W-1:0]         green_limit,
    input  logic [YELLOW_W-1:0]        yellow_limit,
    output logic [ZONE_W-1:0]          zone,
    output logic signed [PITCH_W-1:0]  pitch_a,
    output logic signed [PITCH_W-1:0]  pitch_b,
    output logic signed [DELTA_W-1:0]  angle_delta
);

    localparam int SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (SHIFT - 1);
    localparam logic signed [ACC_W-1:0] PITCH_LIM = ACC_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic [ROOT_W-1:0] DEN_MIN = ROOT_W'(256);
    localparam logic [5:0] SQRT_TOP = 6'(2 * (SQRT_STEPS - 1));

    logic signed [IN_W-1:0]    ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [SQ_W-1:0]           prod_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [REM_W-1:0]          root_reg;
    logic signed [VEC_W-1:0]   cx_reg, cy_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PITCH_W-1:0] pa_reg, pb_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [ZONE_W-1:0]         zone_reg;
    logic [ZONE_W-1:0]         zone_out_reg;
    logic signed [PITCH_W-1:0] pa_out_reg, pb_out_reg;
    logic signed [DELTA_W-1:0] delta_out_reg;

    logic signed [IN_W-1:0]    sel_x, sel_y, sel_z, mult_in;
    logic signed [SQ_W-1:0]    prod;
    logic [5:0]                sq_shamt;
    logic [REM_W-1:0]          sbit;
    logic [REM_W:0]            trial;
    logic [ROOT_W-1:0]         root;
    logic [ROOT_W-1:0]         den;
    logic signed [VEC_W-1:0]   dx, dy;
    logic signed [ACC_W-1:0]   atan_val;
    logic signed [ACC_W-1:0]   rounded, shifted, clamped;
    logic signed [DELTA_W-1:0] diff;
    logic [DELTA_W-1:0]        abs_diff;
    logic [ZONE_W-1:0]         zone_calc;

    assign sel_x   = cmd.sel_b ? bx_reg : ax_reg;
    assign sel_y   = cmd.sel_b ? by_reg : ay_reg;
    assign sel_z   = cmd.sel_b ? bz_reg : az_reg;
    assign mult_in = (cmd.op == OP_SQ_Z) ? sel_z : sel_y;
    assign prod    = mult_in * mult_in;

    assign sq_shamt = SQRT_TOP - {cmd.step, 1'b0};
    assign sbit     = REM_W'(1) << sq_shamt;
    assign trial    = {1'b0, root_reg} + {1'b0, sbit};

    assign root = root_reg[ROOT_W-1:0];
    assign den  = (root < DEN_MIN) ? DEN_MIN : root;

    assign dx       = cy_reg >>> cmd.step;
    assign dy       = cx_reg >>> cmd.step;
    assign atan_val = signed'({2'b00, atan_lookup(cmd.step)});

    assign rounded = acc_reg + ROUND_ADD;
    assign shifted = rounded >>> SHIFT;
    always_comb
    begin
        priority if (shifted > PITCH_LIM)
            clamped = PITCH_LIM;
        else if (shifted < -PITCH_LIM)
            clamped = -PITCH_LIM;
        else
            clamped = shifted;
    end

    assign diff     = DELTA_W'(pb_reg) - DELTA_W'(pa_reg);
    assign abs_diff = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
    always_comb
    begin
        priority if (abs_diff < DELTA_W'(green_limit))
            zone_calc = ZONE_GREEN;
        else if (abs_diff < DELTA_W'(yellow_limit))
            zone_calc = ZONE_YELLOW;
        else
            zone_calc = ZONE_RED;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ax_reg <= accel_a_x;
            ay_reg <= accel_a_y;
            az_reg <= accel_a_z;
            bx_reg <= accel_b_x;
            by_reg <= accel_b_y;
            bz_reg <= accel_b_z;
        end

        unique case (cmd.op)
            OP_SQ_Y:
            begin
                prod_reg <= SQ_W'(prod);
            end
            OP_SQ_Z:
            begin
                sq_reg   <= prod_reg;
                prod_reg <= SQ_W'(prod);
            end
            OP_SQ_SUM:
            begin
                rem_reg  <= {sq_reg + prod_reg, 16'b0};
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg  <= rem_reg - trial[REM_W-1:0];
                    root_reg <= (root_reg >> 1) + sbit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_CINIT:
            begin
                cx_reg  <= signed'(VEC_W'(den));
                cy_reg  <= {{(VEC_W-IN_W-8){sel_x[IN_W-1]}}, sel_x, 8'b0};
                acc_reg <= '0;
            end
            OP_CITER:
            begin
                if (!cy_reg[VEC_W-1])
                begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    acc_reg <= acc_reg + atan_val;
                end
                else
                begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    acc_reg <= acc_reg - atan_val;
                end
            end
            OP_CFIN:
            begin
                if (cmd.sel_b)
                    pb_reg <= clamped[PITCH_W-1:0];
                else
                    pa_reg <= clamped[PITCH_W-1:0];
            end
            OP_DIFF:
            begin
                delta_reg <= diff;
                zone_reg  <= zone_calc;
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            if (cmd.run)
            begin
                zone_out_reg  <= zone_reg;
                pa_out_reg    <= pa_reg;
                pb_out_reg    <= pb_reg;
                delta_out_reg <= delta_reg;
            end
            else
            begin
                zone_out_reg  <= ZONE_STOP;
                pa_out_reg    <= '0;
                pb_out_reg    <= '0;
                delta_out_reg <= '0;
            end
        end
    end

    assign zone        = zone_out_reg;
    assign pitch_a     = pa_out_reg;
    assign pitch_b     = pb_out_reg;
    assign angle_delta = delta_out_reg;

endmodule

// ----- hw/rtl/dual_tilt_delta_zone_unit.sv -----
// Channel  Dir  Beat
// s_*      in   button level and raw x/y/z of sensors A and B
// m_*      out  run flag, zone, both pitches and their difference
// apb      in   green_limit (0x0), yellow_limit (0x4)
//
// Running: a 24-step square root and an N-step CORDIC pass per sensor run on one
// shared datapath before the next beat is taken (N = CORDIC iterations, at most
// 24). Stopped: the beat goes straight to the output stage with zeroed values.
// rst_n clears the run flag and the output valid, sets the button history high and the limits to their reset values.
// A finished beat waits in the output register; the next input beat is taken
// meanwhile, and a result holds in its state until m_tready frees the register.
module dual_tilt_delta_zone_unit
    import dtdz_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // button_level, accel_a_x, accel_a_y, accel_a_z, accel_b_x, accel_b_y,
    // accel_b_z, zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // running, zone, pitch_a, pitch_b, angle_delta, zero pad
    output logic [47:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [GREEN_W-1:0]        green_reg;
    logic [YELLOW_W-1:0]       yellow_reg;
    cmd_t                      cmd;
    logic                      running_out_reg;
    logic [ZONE_W-1:0]         zone;
    logic signed [PITCH_W-1:0] pitch_a, pitch_b;
    logic signed [DELTA_W-1:0] angle_delta;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_YELLOW) ? 32'(yellow_reg) : 32'(green_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= GREEN_RESET;
            yellow_reg <= YELLOW_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_YELLOW)
                yellow_reg <= pwdata[YELLOW_W-1:0];
            else
                green_reg <= pwdata[GREEN_W-1:0];
        end
    end

    dtdz_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .button_level (s_tdata[0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cmd          (cmd)
    );

    dtdz_datapath u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .accel_a_x    (s_tdata[16:1]),
        .accel_a_y    (s_tdata[32:17]),
        .accel_a_z    (s_tdata[48:33]),
        .accel_b_x    (s_tdata[64:49]),
        .accel_b_y    (s_tdata[80:65]),
        .accel_b_z    (s_tdata[96:81]),
        .green_limit  (green_reg),
        .yellow_limit (yellow_reg),
        .zone         (zone),
        .pitch_a      (pitch_a),
        .pitch_b      (pitch_b),
        .angle_delta  (angle_delta)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            running_out_reg <= cmd.run;
    end

    assign m_tdata = {2'b00, angle_delta, pitch_b, pitch_a, zone, running_out_reg};

endmodule

// ----- verif/dual_tilt_delta_zone_check.sv -----
module dual_tilt_delta_zone_check
    import dtdz_pkg::*;
#(
    parameter int ITERS = CORDIC_ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           backlog
);

    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam longint PITCH_LIM = 90 * (1 << ANGLE_FRAC_BITS);

    typedef struct {
        logic                running;
        logic [ZONE_W-1:0]   zone;
        logic [PITCH_W-1:0]  pitch_a;
        logic [PITCH_W-1:0]  pitch_b;
        logic [DELTA_W-1:0]  delta;
    } tilt_t;

    tilt_t               pending_tilts[$];
    tilt_t               want;
    tilt_t               got;
    logic                run_on;
    logic                btn_prev;
    logic [GREEN_W-1:0]  green_lim;
    logic [YELLOW_W-1:0] yellow_lim;
    longint              pa;
    longint              pb;
    longint              dl;
    longint              mag;
    int                  fails;

    // atan(2^-i), degrees scaled by 2^16
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            20: return 4;
            21: return 2;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint tilt_pitch(input logic [15:0] rx, input logic [15:0] ry,
                                          input logic [15:0] rz);
        longint          x;
        longint          y;
        longint          z;
        longint          cx;
        longint          cy;
        longint          dx;
        longint          dy;
        longint          acc;
        longint          res;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        int              i;
        x = longint'($signed(rx));
        y = longint'($signed(ry));
        z = longint'($signed(rz));
        // horizontal magnitude, 8 fraction bits, truncated
        rem = longint'(y * y + z * z) << 16;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        cx = (root < 256) ? 64'sd256 : longint'(root);
        cy = x * 256;
        acc = 0;
        for (i = 0; i < ITERS && i < ATAN_TABLE_LEN; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                acc = acc + atan_step(i);
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                acc = acc - atan_step(i);
            end
        end
        res = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (res > PITCH_LIM)
            res = PITCH_LIM;
        if (res < -PITCH_LIM)
            res = -PITCH_LIM;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_tilts.delete();
            run_on = 1'b0;
            btn_prev = 1'b1;
            green_lim = GREEN_RESET;
            yellow_lim = YELLOW_RESET;
            fails = 0;
            mismatches <= 0;
            backlog <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_GREEN, 2'b00})
                    green_lim = pwdata[GREEN_W-1:0];
                else if (paddr == {REG_YELLOW, 2'b00})
                    yellow_lim = pwdata[YELLOW_W-1:0];
            end

            if (m_tvalid && m_tready)
            begin
                got.running = m_tdata[0];
                got.zone    = m_tdata[2:1];
                got.pitch_a = m_tdata[16:3];
                got.pitch_b = m_tdata[30:17];
                got.delta   = m_tdata[45:31];
                if (pending_tilts.size() == 0)
                begin
                    if (fails < 10)
                        $display("result beat with nothing expected: %h", m_tdata);
                    fails++;
                end
                else
                begin
                    want = pending_tilts.pop_front();
                    if (got.running !== want.running || got.zone !== want.zone ||
                        got.pitch_a !== want.pitch_a || got.pitch_b !== want.pitch_b ||
                        got.delta !== want.delta)
                    begin
                        if (fails < 10)
                        begin
                            $write("mismatch (exp/got): running %0d/%0d zone %0d/%0d ",
                                   want.running, got.running, want.zone, got.zone);
                            $display("pitch_a %0d/%0d pitch_b %0d/%0d delta %0d/%0d",
                                     $signed(want.pitch_a), $signed(got.pitch_a),
                                     $signed(want.pitch_b), $signed(got.pitch_b),
                                     $signed(want.delta), $signed(got.delta));
                        end
                        fails++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (!s_tdata[0] && btn_prev)
                    run_on = !run_on;
                btn_prev = s_tdata[0];
                want.running = run_on;
                want.zone = ZONE_STOP;
                want.pitch_a = '0;
                want.pitch_b = '0;
                want.delta = '0;
                if (run_on)
                begin
                    pa = tilt_pitch(s_tdata[16:1], s_tdata[32:17], s_tdata[48:33]);
                    pb = tilt_pitch(s_tdata[64:49], s_tdata[80:65], s_tdata[96:81]);
                    dl = pb - pa;
                    mag = (dl < 0) ? -dl : dl;
                    if (mag < longint'(green_lim))
                        want.zone = ZONE_GREEN;
                    else if (mag < longint'(yellow_lim))
                        want.zone = ZONE_YELLOW;
                    else
                        want.zone = ZONE_RED;
                    want.pitch_a = pa[PITCH_W-1:0];
                    want.pitch_b = pb[PITCH_W-1:0];
                    want.delta = dl[DELTA_W-1:0];
                end
                pending_tilts.push_back(want);
            end

            mismatches <= fails;
            backlog <= pending_tilts.size();
        end
    end

endmodule

// ----- verif/dual_tilt_delta_zone_unit_test.sv -----
module dual_tilt_delta_zone_unit_test;
    import dtdz_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BEATS  = 282;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int mismatches;
    int backlog;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;
    bit gen_btn_prev = 1'b1;
    bit gen_running = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    dual_tilt_delta_zone_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dual_tilt_delta_zone_check tilt_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("dual_tilt_delta_zone_unit_test NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [103:0] sample_beat(input bit btn,
                                                 input logic [15:0] ax, input logic [15:0] ay,
                                                 input logic [15:0] az, input logic [15:0] bx,
                                                 input logic [15:0] by, input logic [15:0] bz);
        return {7'b0, bz, by, bx, az, ay, ax, btn};
    endfunction

    function automatic logic [15:0] axis_near(input int center, input int span);
        int v;
        v = center + int'($urandom_range(2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] axis_corner();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic random_sensor(output logic [15:0] x, output logic [15:0] y,
                                 output logic [15:0] z);
        int style;
        style = $urandom_range(9);
        if (style <= 2)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        else if (style <= 5)
        begin
            // roughly 1 g along z, tilted
            x = axis_near(0, 16384);
            y = axis_near(0, 3000);
            z = axis_near($urandom_range(1) ? 16384 : -16384, 4000);
        end
        else if (style == 6)
        begin
            x = 16'($urandom);
            y = '0;
            z = '0;
        end
        else if (style == 7)
        begin
            x = axis_corner();
            y = axis_corner();
            z = axis_corner();
        end
        else if (style == 8)
        begin
            x = axis_near(0, 8);
            y = axis_near(0, 8);
            z = axis_near(0, 8);
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = '0;
        end
    endtask

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send(input logic [103:0] d);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!d[0] && gen_btn_prev)
            gen_running = !gen_running;
        gen_btn_prev = d[0];
        @(negedge clk);
    endtask

    task automatic random_beat();
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        bit          btn;
        if (!gen_btn_prev)
            btn = ($urandom_range(99) < 60);
        else
            btn = !($urandom_range(99) < (gen_running ? 3 : 40));
        random_sensor(ax, ay, az);
        if ($urandom_range(99) < 40)
        begin
            bx = axis_near(int'($signed(ax)), 300);
            by = ay;
            bz = az;
        end
        else
            random_sensor(bx, by, bz);
        send(sample_beat(btn, ax, ay, az, bx, by, bz));
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] green_val;
        logic [31:0] yellow_val;
        int          ph;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset limits
        send(sample_beat(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(sample_beat(1'b0, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000));
        send(sample_beat(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(sample_beat(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send(sample_beat(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
        send(sample_beat(1'b1, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
        send(sample_beat(1'b1, 16'd16384, 16'h0000, 16'd16384, 16'd16384, 16'h0000,
                         16'd16384));
        send(sample_beat(1'b1, 16'h0000, 16'h0000, 16'd16384, 16'd4390, 16'h0000,
                         16'd16384));
        send(sample_beat(1'b1, 16'h0000, 16'h0000, 16'd16384, 16'd7640, 16'h0000,
                         16'd16384));
        send(sample_beat(1'b1, 16'h0000, 16'h0000, 16'd16384, -16'sd19526, 16'h0000,
                         16'd16384));
        send(sample_beat(1'b1, 16'h1234, -16'sd300, 16'hC000, 16'h1200, 16'h0100,
                         16'hC100));
        send(sample_beat(1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0FED, 16'hCBA9));
        send(sample_beat(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        send(sample_beat(1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send(sample_beat(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send(sample_beat(1'b1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        settle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    green_val = 32'd0;
                    yellow_val = 32'd0;
                end
                1:
                begin
                    green_val = 32'd5760;
                    yellow_val = 32'd11520;
                end
                2:
                begin
                    green_val = 32'hFFFF_FFFF;
                    yellow_val = 32'hFFFF_FFFF;
                end
                3:
                begin
                    // yellow below green: no yellow zone
                    green_val = 32'd2000;
                    yellow_val = 32'd1000;
                end
                4:
                begin
                    green_val = $urandom_range(5760);
                    yellow_val = $urandom_range(11520);
                end
                default:
                begin
                    green_val = GREEN_RESET;
                    yellow_val = YELLOW_RESET;
                end
            endcase
            apb_write({REG_GREEN, 2'b00}, green_val);
            apb_write({REG_YELLOW, 2'b00}, yellow_val);
            send_idle = (ph < 2) ? 18 : (ph < 4) ? 80 : 0;
            recv_idle = (ph < 2) ? 80 : (ph < 4) ? 18 : 0;
            repeat (PHASE_BEATS) random_beat();
            settle();
        end

        if (mismatches == 0 && backlog == 0)
            $display("dual_tilt_delta_zone_unit_test OK");
        else
            $display("dual_tilt_delta_zone_unit_test NOT OK");
        $finish;
    end

endmodule
